// ----- src/asl_pkg.sv -----
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the assembly source lexer
// Token kinds, error codes, per-byte character information and byte
// classification used by the front and back parts of the lexer.
// ----------------------------------------------------------------------------
package asl_pkg;

    // Longest token is TOKEN_MAX-1 bytes
    localparam int TOKEN_MAX = 512;
    localparam int LEN_W     = $clog2(TOKEN_MAX);

    // Byte constants
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [3:0] {
        K_SPACE   = 4'd0,
        K_NEWLINE = 4'd1,
        K_LABEL   = 4'd2,
        K_WORD    = 4'd3,
        K_HEX     = 4'd4,
        K_DEC     = 4'd5,
        K_STRING  = 4'd6,
        K_COMMENT = 4'd7,
        K_UNKNOWN = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE     = 2'd0,
        E_ESCAPE   = 2'd1,
        E_TOO_LONG = 2'd2
    } t_err;

    // Classified source byte, as queued between front and back
    typedef struct packed {
        logic [7:0] ch;
        t_kind      cls;
        logic       is_space;
        logic       is_digit;
        logic       is_letter;
        logic       is_hex;
        logic       is_under;
        logic       is_colon;
        logic       is_x;
        logic       is_minus;
        logic       is_bslash;
        logic       is_quote;
        logic       is_lf;
        logic       esc_ok;
        logic [7:0] esc_ch;
    } t_char_info;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic f_is_hex(input logic [7:0] c);
        return f_is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Kind of a token opened by this byte
    function automatic t_kind f_classify(input logic [7:0] c);
        t_kind k;
        if ((c == CH_SPACE) || (c == CH_TAB))         k = K_SPACE;
        else if (f_is_digit(c) || (c == CH_MINUS))    k = K_DEC;
        else if (f_is_letter(c))                      k = K_WORD;
        else if (c == CH_SLASH)                       k = K_COMMENT;
        else if (c == CH_QUOTE)                       k = K_STRING;
        else if (c == CH_LF)                          k = K_NEWLINE;
        else                                          k = K_UNKNOWN;
        return k;
    endfunction

endpackage

// ----- src/asl_front.sv -----
// ----------------------------------------------------------------------------
// asl_front: byte classifier
// Tags each incoming byte with its character classes, the kind of token it
// would open and its escape translation, ready for the queue.
// ----------------------------------------------------------------------------
module asl_front (
    input  logic              [7:0] i_char,
    output asl_pkg::t_char_info     o_info
);

    // Classify the byte
    always_comb begin
        o_info           = '0;
        o_info.ch        = i_char;
        o_info.cls       = asl_pkg::f_classify(i_char);
        o_info.is_space  = (i_char == asl_pkg::CH_SPACE) || (i_char == asl_pkg::CH_TAB);
        o_info.is_digit  = asl_pkg::f_is_digit(i_char);
        o_info.is_letter = asl_pkg::f_is_letter(i_char);
        o_info.is_hex    = asl_pkg::f_is_hex(i_char);
        o_info.is_under  = (i_char == asl_pkg::CH_UNDER);
        o_info.is_colon  = (i_char == asl_pkg::CH_COLON);
        o_info.is_x      = (i_char == asl_pkg::CH_X);
        o_info.is_minus  = (i_char == asl_pkg::CH_MINUS);
        o_info.is_bslash = (i_char == asl_pkg::CH_BSLASH);
        o_info.is_quote  = (i_char == asl_pkg::CH_QUOTE);
        o_info.is_lf     = (i_char == asl_pkg::CH_LF);

        // Resolve the escape that this byte would complete
        o_info.esc_ok = 1'b1;
        case (i_char)
            asl_pkg::CH_BSLASH: o_info.esc_ch = asl_pkg::CH_BSLASH;
            asl_pkg::CH_N:      o_info.esc_ch = asl_pkg::CH_LF;
            asl_pkg::CH_ZERO:   o_info.esc_ch = asl_pkg::CH_NUL;
            asl_pkg::CH_R:      o_info.esc_ch = asl_pkg::CH_CR;
            asl_pkg::CH_T:      o_info.esc_ch = asl_pkg::CH_TAB;
            default: begin
                o_info.esc_ok = 1'b0;
                o_info.esc_ch = i_char;
            end
        endcase
    end

endmodule

// ----- src/asl_queue.sv -----
// ----------------------------------------------------------------------------
// asl_queue: two-entry request queue
// Decouples the classifier from the token tracker so either side can stall.
// ----------------------------------------------------------------------------
module asl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  asl_pkg::t_char_info i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output asl_pkg::t_char_info o_data
);

    asl_pkg::t_char_info r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Store a request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/asl_back.sv -----
// ----------------------------------------------------------------------------
// asl_back: token tracker
// Holds the lexer state, decides join, open and close for each queued byte
// and drives the result register.
// ----------------------------------------------------------------------------
module asl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  asl_pkg::t_char_info i_info,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic          [7:0] o_char_out,
    output logic          [3:0] o_token_kind,
    output logic                o_token_start,
    output logic                o_token_closed,
    output logic          [1:0] o_error_code
);

    asl_pkg::t_kind             r_kind, n_kind;
    logic [asl_pkg::LEN_W-1:0]  r_len, n_len;
    logic                       r_minus, n_minus;
    logic                       r_open, n_open;
    logic                       r_esc, n_esc;
    asl_pkg::t_err              r_sticky, n_sticky;

    logic                       r_out_valid;
    logic [7:0]                 r_char, n_char;
    asl_pkg::t_kind             r_okind, n_okind;
    logic                       r_start, n_start;
    logic                       r_closed, n_closed;
    asl_pkg::t_err              r_err, n_err;
    logic                       n_emit;

    logic                       w_join;
    logic                       w_close;
    asl_pkg::t_kind             w_jkind;
    logic [7:0]                 w_jchar;
    logic                       w_done;

    // Take a request whenever the result register is free or drains
    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    // Decide the result of one byte
    always_comb begin
        n_kind   = r_kind;
        n_len    = r_len;
        n_minus  = r_minus;
        n_open   = r_open;
        n_esc    = r_esc;
        n_sticky = r_sticky;
        n_emit   = 1'b0;
        n_char   = i_info.ch;
        n_okind  = r_kind;
        n_start  = 1'b0;
        n_closed = 1'b0;
        n_err    = asl_pkg::E_NONE;
        w_join   = 1'b0;
        w_close  = 1'b0;
        w_jkind  = r_kind;
        w_jchar  = i_info.ch;
        w_done   = 1'b0;

        if (r_sticky != asl_pkg::E_NONE) begin
            // drop everything after an error
            w_done = 1'b1;
        end else if (r_esc) begin
            n_esc = 1'b0;
            if (i_info.esc_ok) begin
                w_join  = 1'b1;
                w_jchar = i_info.esc_ch;
            end else begin
                n_sticky = asl_pkg::E_ESCAPE;
                n_emit   = 1'b1;
                n_err    = asl_pkg::E_ESCAPE;
                w_done   = 1'b1;
            end
        end else if (r_open) begin
            case (r_kind)
                asl_pkg::K_WORD: begin
                    if (i_info.is_letter || i_info.is_under) begin
                        w_join = 1'b1;
                    end else if (i_info.is_colon) begin
                        w_join  = 1'b1;
                        w_close = 1'b1;
                        w_jkind = asl_pkg::K_LABEL;
                    end
                end
                asl_pkg::K_HEX:     w_join = i_info.is_hex;
                asl_pkg::K_DEC: begin
                    if (i_info.is_digit) begin
                        w_join = 1'b1;
                    end else if (i_info.is_x && (r_len == asl_pkg::LEN_W'(1)) && !r_minus) begin
                        w_join  = 1'b1;
                        w_jkind = asl_pkg::K_HEX;
                    end
                end
                asl_pkg::K_SPACE:   w_join = i_info.is_space;
                asl_pkg::K_STRING: begin
                    if (i_info.is_bslash) begin
                        n_esc  = 1'b1;
                        w_done = 1'b1;
                    end else begin
                        w_join  = 1'b1;
                        w_close = i_info.is_quote;
                    end
                end
                asl_pkg::K_COMMENT: w_join = !i_info.is_lf;
                default:            w_join = 1'b0;
            endcase
        end

        if (!w_done) begin
            n_emit = 1'b1;
            if (w_join) begin
                n_char = w_jchar;
                if (r_len >= asl_pkg::LEN_W'(asl_pkg::TOKEN_MAX - 1)) begin
                    n_sticky = asl_pkg::E_TOO_LONG;
                    n_err    = asl_pkg::E_TOO_LONG;
                end else begin
                    n_len    = r_len + 1'b1;
                    n_kind   = w_jkind;
                    n_okind  = w_jkind;
                    n_closed = w_close;
                    if (w_close) n_open = 1'b0;
                end
            end else begin
                // open a new token with this byte
                n_kind   = i_info.cls;
                n_okind  = i_info.cls;
                n_len    = asl_pkg::LEN_W'(1);
                n_minus  = (i_info.cls == asl_pkg::K_DEC) && i_info.is_minus;
                n_start  = 1'b1;
                n_closed = (i_info.cls == asl_pkg::K_NEWLINE)
                        || (i_info.cls == asl_pkg::K_UNKNOWN);
                n_open   = !n_closed;
            end
        end
    end

    // Update lexer state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= asl_pkg::K_SPACE;
            r_len       <= '0;
            r_minus     <= 1'b0;
            r_open      <= 1'b0;
            r_esc       <= 1'b0;
            r_sticky    <= asl_pkg::E_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_kind   <= n_kind;
                r_len    <= n_len;
                r_minus  <= n_minus;
                r_open   <= n_open;
                r_esc    <= n_esc;
                r_sticky <= n_sticky;
            end
            if (o_pop) begin
                r_out_valid <= n_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_char   <= n_char;
            r_okind  <= n_okind;
            r_start  <= n_start;
            r_closed <= n_closed;
            r_err    <= n_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_char_out     = r_char;
    assign o_token_kind   = r_okind;
    assign o_token_start  = r_start;
    assign o_token_closed = r_closed;
    assign o_error_code   = r_err;

endmodule

// ----- src/assembly_source_lexer_top.sv -----
// ----------------------------------------------------------------------------
// assembly_source_lexer_top: assembly source lexer
// Splits a source byte stream into typed tokens, one result per byte at most.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   input   | in        | i_valid / o_ready   | i_char_in
//   result  | out       | o_valid / i_ready   | o_char_out, o_token_kind,
//           |           |                     | o_token_start, o_token_closed,
//           |           |                     | o_error_code
//
// One byte per cycle sustained while results are taken; an accepted byte is
// written into the queue, and the tracker's state update then loads its
// result into the result register, from which it can be taken.
// Synchronous active-low reset clears the state, queue and result valid.
// A stalled result holds the tracker while the two-entry queue keeps taking
// bytes until it fills.
// ----------------------------------------------------------------------------
module assembly_source_lexer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic [3:0] o_token_kind,
    output logic       o_token_start,
    output logic       o_token_closed,
    output logic [1:0] o_error_code
);

    asl_pkg::t_char_info w_in_info;
    asl_pkg::t_char_info w_head;
    logic                w_full;
    logic                w_empty;
    logic                w_pop;

    assign o_ready = !w_full;

    // Classify incoming bytes
    asl_front u_front (
        .i_char (i_char_in),
        .o_info (w_in_info)
    );

    // Queue classified requests
    asl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (w_in_info),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    // Track tokens and drive results
    asl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_info         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_out     (o_char_out),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_closed (o_token_closed),
        .o_error_code   (o_error_code)
    );

endmodule
